// File: sv/fdbm_pkg.sv
// ----------------------------------------------------------------------------
// fdbm_pkg
// Shared types, codes, constants and the sine lookup of the FSK burst
// modulator.
// ----------------------------------------------------------------------------
package fdbm_pkg;

  localparam int DEF_MAX_BITS = 1024;

  localparam int PHASE_W  = 32;
  localparam int SPB_W    = 16;
  localparam int DAC_W    = 8;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DAC_W-1:0] DAC_MID = 8'd128;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACE_STEP = 2'd0,
    REG_MARK_STEP  = 2'd1,
    REG_SPB        = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_FETCH
  } state_t;

  // First quarter of the wave, floor(127.5 + 127.5*sin(pi*k/128)).
  localparam logic [7:0] QUARTER_WAVE [65] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255
  };

  function automatic logic [DAC_W-1:0] sine_rom(input logic [7:0] idx);
    logic [7:0] j;
    logic [7:0] k;
    logic [7:0] v;
    j = {1'b0, idx[6:0]};
    k = (j <= 8'd64) ? j : (8'd128 - j);
    v = QUARTER_WAVE[k[6:0]];
    if (idx[7]) begin
      v = (k == 8'd64) ? 8'd0 : (8'd254 - v);
    end
    return v;
  endfunction

endpackage

// File: sv/fdbm_item_if.sv
// ----------------------------------------------------------------------------
// fdbm_item_if
// Input channel of the FSK burst modulator: one command per request.
// ----------------------------------------------------------------------------
interface fdbm_item_if
  import fdbm_pkg::*;
  ();
  logic valid;
  logic ready;
  op_t  op;
  logic bit_value;

  modport source (output valid, output op, output bit_value, input ready);
  modport sink (input valid, input op, input bit_value, output ready);
endinterface

// File: sv/fdbm_result_if.sv
// ----------------------------------------------------------------------------
// fdbm_result_if
// Output channel of the FSK burst modulator: one result per request.
// ----------------------------------------------------------------------------
interface fdbm_result_if
  import fdbm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [DAC_W-1:0]   dac_value;
  logic               transmitting;
  logic               burst_done;
  logic [COUNT_W-1:0] stored_bits;

  modport source (output valid, output dac_value, output transmitting,
                  output burst_done, output stored_bits, input ready);
  modport sink (input valid, input dac_value, input transmitting,
                input burst_done, input stored_bits, output ready);
endinterface

// File: sv/fdbm_cfg_if.sv
// ----------------------------------------------------------------------------
// fdbm_cfg_if
// Register write channel of the FSK burst modulator.
// ----------------------------------------------------------------------------
interface fdbm_cfg_if
  import fdbm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/fsk_dds_burst_modulator.sv
// ----------------------------------------------------------------------------
// fsk_dds_burst_modulator
// Binary FSK burst generator on a direct digital synthesizer. Bits are
// collected in an on-chip store and played out as mark and space tones.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   item      in         op, bit_value
//   result    out        dac_value, transmitting, burst_done, stored_bits
//   cfg       in         index, data (register writes, always ready)
//
// A start with bits in the store, and a tick that moves on to another bit,
// pass through ST_FETCH, where no request is taken: the bit store read is
// registered and the new phase step is loaded from its read data.
// The result register lets the next request in while the taker is free or
// draining it in the same cycle. Reset is synchronous; the bit store is not
// cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
module fsk_dds_burst_modulator
  import fdbm_pkg::*;
#(
  parameter int MAX_BITS = DEF_MAX_BITS
) (
  input  logic          clk,
  input  logic          rst,
  fdbm_item_if.sink     item,
  fdbm_result_if.source result,
  fdbm_cfg_if.sink      cfg
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int CW = $clog2(MAX_BITS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BITS);

  logic [PHASE_W-1:0] space_phase_step;
  logic [PHASE_W-1:0] mark_phase_step;
  logic [SPB_W-1:0]   samples_per_bit;

  logic               store [MAX_BITS];
  logic               rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  state_t             state;
  state_t             state_next;

  logic [CW-1:0]      bit_total;
  logic [CW-1:0]      bit_total_next;
  logic [CW-1:0]      bit_position;
  logic [CW-1:0]      bit_position_next;
  logic [SPB_W-1:0]   sample_count;
  logic [SPB_W-1:0]   sample_count_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] phase_step;
  logic               active;
  logic               active_next;

  logic               accept;
  logic               fetch;
  logic               load_step;
  logic               done;
  logic [DAC_W-1:0]   dac;
  logic [SPB_W-1:0]   sc_inc;
  logic [CW-1:0]      pos_inc;

  assign accept    = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_phase_step <= '0;
      mark_phase_step  <= '0;
      samples_per_bit  <= SPB_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SPACE_STEP: space_phase_step <= cfg.data;
        REG_MARK_STEP:  mark_phase_step  <= cfg.data;
        REG_SPB:        samples_per_bit  <= cfg.data[SPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bit_total_next    = bit_total;
    bit_position_next = bit_position;
    sample_count_next = sample_count;
    phase_next        = phase;
    active_next       = active;
    wr_en             = 1'b0;
    fetch             = 1'b0;
    done              = 1'b0;
    dac               = DAC_MID;
    rd_addr           = '0;
    sc_inc            = sample_count + SPB_W'(1);
    pos_inc           = bit_position + CW'(1);
    if (accept) begin
      unique case (item.op)
        OP_CLEAR: begin
          if (!active) begin
            bit_total_next = '0;
          end
        end
        OP_PUSH: begin
          if (!active && bit_total < MAX_COUNT) begin
            wr_en          = 1'b1;
            bit_total_next = bit_total + CW'(1);
          end
        end
        OP_START: begin
          if (!active) begin
            bit_position_next = '0;
            sample_count_next = '0;
            phase_next        = '0;
            if (bit_total == '0) begin
              done = 1'b1;
            end else begin
              active_next = 1'b1;
              fetch       = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (active) begin
            dac        = sine_rom(phase[PHASE_W-1 -: 8]);
            phase_next = phase + phase_step;
            if (sc_inc >= samples_per_bit || samples_per_bit == '0) begin
              sample_count_next = '0;
              bit_position_next = pos_inc;
              if (pos_inc >= bit_total) begin
                active_next = 1'b0;
                done        = 1'b1;
              end else begin
                fetch   = 1'b1;
                rd_addr = pos_inc[AW-1:0];
              end
            end else begin
              sample_count_next = sc_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[bit_total[AW-1:0]] <= item.bit_value;
    end
    rd_data <= store[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (accept && fetch) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_ACCEPT;
      default:  state_next = ST_ACCEPT;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    load_step  = 1'b0;
    unique case (state)
      ST_ACCEPT: item.ready = !result.valid || result.ready;
      ST_FETCH:  load_step  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACCEPT;
      bit_total    <= '0;
      bit_position <= '0;
      sample_count <= '0;
      phase        <= '0;
      phase_step   <= '0;
      active       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state        <= state_next;
      bit_total    <= bit_total_next;
      bit_position <= bit_position_next;
      sample_count <= sample_count_next;
      phase        <= phase_next;
      active       <= active_next;
      if (load_step) begin
        phase_step <= rd_data ? mark_phase_step : space_phase_step;
      end
      if (accept) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.dac_value    <= dac;
      result.transmitting <= active_next;
      result.burst_done   <= done;
      result.stored_bits  <= COUNT_W'(bit_total_next);
    end
  end

endmodule
